### rtl/modular_arithmetic_unit_top_assert.svh
// Assertion macros for the modular arithmetic unit.
`ifndef MODULAR_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MAU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/mau_pkg.sv
// Package: types, codes and constants of the modular arithmetic unit.
`default_nettype none
package mau_pkg;
    localparam int unsigned ResW = 31;
    localparam logic [30:0] ModulusReset = 31'd1000000007;

    typedef enum logic [3:0] {
        FN_REDUCE = 4'd0, FN_NEG = 4'd1, FN_ADD = 4'd2, FN_SUB = 4'd3,
        FN_MUL = 4'd4, FN_DIV = 4'd5, FN_POW = 4'd6, FN_INV = 4'd7,
        FN_EQ = 4'd8
    } func_t;

    typedef struct packed {
        logic [3:0]  func;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
        logic [62:0] exponent;
    } in_item_t;

    typedef struct packed {
        logic [30:0] result;
        logic        not_invertible;
    } out_item_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_RED_A, OP_RED_B, OP_FIX_A, OP_FIX_B, OP_SIMPLE,
        OP_MUL_START, OP_MUL_STEP, OP_POW_SQ, OP_POW_MUL, OP_POW_SHIFT,
        OP_GCD_INIT, OP_GCD_STEP, OP_INV_FIX, OP_DIV_MUL
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_RED, ST_FIX, ST_DISPATCH, ST_MUL, ST_POW,
        ST_POW_WAIT, ST_GCD, ST_INV_FIX, ST_DIV_MUL, ST_DONE, ST_OUT
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel_b;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  div_done;   // divider finished current reduction
        logic  exp_zero;
        logic  exp_lsb;
        logic  gcd_done;
        logic  gcd_one;
        logic  m_is_one;
    } dp_status_t;

    localparam logic [0:0] RegModulus = 1'b0;
endpackage
`default_nettype wire

### rtl/mau_datapath.sv
// Datapath: restoring divider for reductions, and register file for pow/gcd.
`default_nettype none
module mau_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mau_pkg::dp_cmd_t       cmd,
    input  wire mau_pkg::in_item_t      item,
    input  wire logic [30:0]            m,
    output mau_pkg::dp_status_t         status,
    output mau_pkg::out_item_t          res
);
    // Divider: reduces a 64-bit dividend by a 31-bit divisor, one bit per cycle;
    // also yields the quotient (used by gcd).
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [30:0] dsr_reg, dsr_next;
    logic        busy_reg, busy_next;

    logic [30:0] a_reg, a_next, b_reg, b_next, acc_reg, acc_next;
    logic [62:0] e_reg, e_next;
    logic        nega_reg, nega_next, negb_reg, negb_next;
    logic [3:0]  f_reg, f_next;
    logic        flag_reg, flag_next;
    logic [1:0]  mdst_reg, mdst_next; // 0 acc (also the div multiply), 1 base(a)
    // gcd: g,h in 0..m ; s,t signed
    logic [31:0] g_reg, g_next, h_reg, h_next;
    logic signed [32:0] s_reg, s_next, t_reg, t_next;
    logic        gphase_reg, gphase_next;
    logic [63:0] mag_b_reg;

    localparam logic [1:0] DstAcc = 2'd0;
    localparam logic [1:0] DstBase = 2'd1;

    logic [31:0] rem_sh;
    logic [32:0] rem_try;
    logic [63:0] mag_a, mag_b;
    logic [30:0] m_eff;
    logic [30:0] mul_rhs;
    logic signed [65:0] qt;
    logic signed [32:0] s_new;
    logic [61:0] prod;

    always_comb
    begin
        m_eff = (m < 31'd2) ? 31'd1 : m;
        mag_a = item.operand_a[63] ? (64'd0 - item.operand_a) : item.operand_a;
        mag_b = item.operand_b[63] ? (64'd0 - item.operand_b) : item.operand_b;
        rem_sh = {rem_reg[30:0], dvd_reg[63]};
        rem_try = {1'b0, rem_sh} - {2'b0, dsr_reg};
        // squaring takes the base on both sides
        if (cmd.op == mau_pkg::OP_POW_SQ)
            mul_rhs = a_reg;
        else
            mul_rhs = cmd.sel_b ? b_reg : acc_reg;
        prod = 62'(a_reg) * 62'(mul_rhs);
        qt = 66'(signed'(quo_reg[32:0])) * 66'(t_reg);
        s_new = 33'(66'(s_reg) - qt);
    end

    always_comb
    begin
        dvd_next = dvd_reg; rem_next = rem_reg; quo_next = quo_reg;
        cnt_next = cnt_reg; dsr_next = dsr_reg; busy_next = busy_reg;
        a_next = a_reg; b_next = b_reg; acc_next = acc_reg; e_next = e_reg;
        nega_next = nega_reg; negb_next = negb_reg; f_next = f_reg;
        flag_next = flag_reg; mdst_next = mdst_reg;
        g_next = g_reg; h_next = h_reg; s_next = s_reg; t_next = t_reg;
        gphase_next = gphase_reg;
        if (busy_reg)
        begin
            dvd_next = {dvd_reg[62:0], 1'b0};
            if (!rem_try[32])
            begin
                rem_next = rem_try[31:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
        unique case (cmd.op)
            mau_pkg::OP_LOAD:
            begin
                f_next = item.func; e_next = item.exponent;
                nega_next = item.operand_a[63]; negb_next = item.operand_b[63];
                flag_next = 1'b0;
                dvd_next = mag_a; rem_next = '0; quo_next = '0;
                dsr_next = m_eff; cnt_next = 7'd64; busy_next = 1'b1;
            end
            mau_pkg::OP_RED_A:
            begin
                a_next = rem_reg[30:0]; dvd_next = mag_b_reg;
                rem_next = '0; quo_next = '0; cnt_next = 7'd64; busy_next = 1'b1;
            end
            mau_pkg::OP_RED_B:
                b_next = rem_reg[30:0];
            mau_pkg::OP_FIX_A:
            begin
                if (nega_reg && a_reg != 31'd0) a_next = dsr_reg - a_reg;
                if (negb_reg && b_reg != 31'd0) b_next = dsr_reg - b_reg;
            end
            mau_pkg::OP_SIMPLE:
            begin
                unique case (f_reg)
                    mau_pkg::FN_REDUCE: acc_next = a_reg;
                    mau_pkg::FN_NEG: acc_next = (a_reg == 31'd0) ? 31'd0 : dsr_reg - a_reg;
                    mau_pkg::FN_ADD:
                    begin
                        if ({1'b0, a_reg} + {1'b0, b_reg} >= {1'b0, dsr_reg})
                            acc_next = 31'({1'b0, a_reg} + {1'b0, b_reg} - {1'b0, dsr_reg});
                        else
                            acc_next = a_reg + b_reg;
                    end
                    mau_pkg::FN_SUB: acc_next = (a_reg >= b_reg) ? a_reg - b_reg
                                                              : dsr_reg - b_reg + a_reg;
                    mau_pkg::FN_EQ: acc_next = {30'd0, a_reg == b_reg};
                    default: acc_next = '0;
                endcase
            end
            mau_pkg::OP_MUL_START, mau_pkg::OP_POW_SQ, mau_pkg::OP_POW_MUL,
            mau_pkg::OP_DIV_MUL:
            begin
                dvd_next = {2'b0, prod}; rem_next = '0; quo_next = '0;
                cnt_next = 7'd64; busy_next = 1'b1;
                mdst_next = (cmd.op == mau_pkg::OP_POW_SQ) ? DstBase : DstAcc;
                if (cmd.op == mau_pkg::OP_POW_SQ && e_reg == 63'd0)
                    busy_next = 1'b0;
            end
            mau_pkg::OP_POW_SHIFT:
            begin
                if (mdst_reg == DstBase) a_next = rem_reg[30:0];
                else acc_next = rem_reg[30:0];
                if (mdst_reg == DstBase) e_next = e_reg >> 1;
            end
            mau_pkg::OP_GCD_INIT:
            begin
                g_next = {1'b0, (f_reg == mau_pkg::FN_DIV) ? b_reg : a_reg};
                h_next = {1'b0, dsr_reg};
                s_next = 33'sd1; t_next = 33'sd0; gphase_next = 1'b0;
                if (dsr_reg == 31'd1) acc_next = 31'd0;
                else acc_next = 31'd1;
            end
            mau_pkg::OP_GCD_STEP:
            begin
                if (!gphase_reg)
                begin
                    dvd_next = {32'd0, g_reg}; rem_next = '0; quo_next = '0;
                    dsr_next = h_reg[30:0]; cnt_next = 7'd64; busy_next = 1'b1;
                    gphase_next = 1'b1;
                end
                else
                begin
                    g_next = h_reg; h_next = rem_reg;
                    s_next = t_reg; t_next = s_new;
                    gphase_next = 1'b0;
                end
            end
            mau_pkg::OP_INV_FIX:
            begin
                dsr_next = m_eff;
                if (g_reg != 32'd1)
                begin
                    acc_next = '0;
                    flag_next = (m_eff != 31'd1);
                end
                else if (s_reg[32])
                    acc_next = 31'(33'(signed'({2'b0, m_eff})) + s_reg);
                else
                    acc_next = s_reg[30:0];
            end
            default: ;
        endcase
        if (cmd.op == mau_pkg::OP_INV_FIX && g_reg == 32'd1 && m_eff == 31'd1)
            acc_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            gphase_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            gphase_reg <= gphase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next; rem_reg <= rem_next; quo_reg <= quo_next;
        dsr_reg <= dsr_next; a_reg <= a_next; b_reg <= b_next;
        acc_reg <= acc_next; e_reg <= e_next; nega_reg <= nega_next;
        negb_reg <= negb_next; f_reg <= f_next; flag_reg <= flag_next;
        mdst_reg <= mdst_next; g_reg <= g_next; h_reg <= h_next;
        s_reg <= s_next; t_reg <= t_next;
        if (cmd.op == mau_pkg::OP_LOAD) mag_b_reg <= mag_b;
    end

    always_comb
    begin
        status.func = mau_pkg::func_t'(f_reg);
        status.div_done = !busy_reg;
        status.exp_zero = (e_reg == 63'd0);
        status.exp_lsb = e_reg[0];
        status.gcd_done = (h_reg == 32'd0);
        status.gcd_one = (g_reg == 32'd1);
        status.m_is_one = (dsr_reg == 31'd1);
        res.result = acc_reg;
        res.not_invertible = flag_reg;
    end
endmodule
`default_nettype wire

### rtl/mau_ctrl.sv
// Controller: sequences reductions, multiplies, pow and gcd loops.
`default_nettype none
module mau_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic                 out_free,
    input  wire mau_pkg::dp_status_t  status,
    output mau_pkg::dp_cmd_t          cmd,
    output logic                      idle,
    output logic                      out_load
);
    mau_pkg::state_t state_reg, state_next;
    logic pow_mul_reg, pow_mul_next;
    logic div_phase_reg, div_phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mau_pkg::ST_IDLE;
            pow_mul_reg <= 1'b0;
            div_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pow_mul_reg <= pow_mul_next;
            div_phase_reg <= div_phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pow_mul_next = pow_mul_reg;
        div_phase_next = div_phase_reg;
        cmd.op = mau_pkg::OP_NONE;
        cmd.sel_b = 1'b0;
        idle = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            mau_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.op = mau_pkg::OP_LOAD;
                    state_next = mau_pkg::ST_LOAD;
                end
            end
            mau_pkg::ST_LOAD:
                if (status.div_done)
                begin
                    cmd.op = mau_pkg::OP_RED_A;
                    state_next = mau_pkg::ST_RED;
                end
            mau_pkg::ST_RED:
                if (status.div_done)
                begin
                    cmd.op = mau_pkg::OP_RED_B;
                    state_next = mau_pkg::ST_FIX;
                end
            mau_pkg::ST_FIX:
            begin
                cmd.op = mau_pkg::OP_FIX_A;
                state_next = mau_pkg::ST_DISPATCH;
            end
            mau_pkg::ST_DISPATCH:
            begin
                unique case (status.func)
                    mau_pkg::FN_MUL:
                    begin
                        cmd.op = mau_pkg::OP_MUL_START;
                        cmd.sel_b = 1'b1;
                        state_next = mau_pkg::ST_MUL;
                    end
                    mau_pkg::FN_POW:
                    begin
                        cmd.op = mau_pkg::OP_GCD_INIT; // sets acc to 1 mod m
                        pow_mul_next = 1'b1;
                        state_next = mau_pkg::ST_POW;
                    end
                    mau_pkg::FN_DIV, mau_pkg::FN_INV:
                    begin
                        cmd.op = mau_pkg::OP_GCD_INIT;
                        state_next = mau_pkg::ST_GCD;
                    end
                    default:
                    begin
                        cmd.op = mau_pkg::OP_SIMPLE;
                        state_next = mau_pkg::ST_DONE;
                    end
                endcase
            end
            mau_pkg::ST_MUL:
                if (status.div_done)
                begin
                    cmd.op = mau_pkg::OP_POW_SHIFT;
                    state_next = mau_pkg::ST_DONE;
                end
            mau_pkg::ST_POW:
            begin
                if (status.exp_zero)
                    state_next = mau_pkg::ST_DONE;
                else if (pow_mul_reg)
                begin
                    pow_mul_next = 1'b0;
                    if (status.exp_lsb)
                    begin
                        cmd.op = mau_pkg::OP_POW_MUL;
                        state_next = mau_pkg::ST_POW_WAIT;
                    end
                end
                else
                begin
                    pow_mul_next = 1'b1;
                    cmd.op = mau_pkg::OP_POW_SQ;
                    cmd.sel_b = 1'b0;
                    state_next = mau_pkg::ST_POW_WAIT;
                end
            end
            mau_pkg::ST_POW_WAIT:
                if (status.div_done)
                begin
                    cmd.op = mau_pkg::OP_POW_SHIFT;
                    state_next = mau_pkg::ST_POW;
                end
            mau_pkg::ST_GCD:
            begin
                if (!div_phase_reg && status.gcd_done)
                begin
                    cmd.op = mau_pkg::OP_INV_FIX;
                    state_next = mau_pkg::ST_INV_FIX;
                end
                else if (!div_phase_reg)
                begin
                    cmd.op = mau_pkg::OP_GCD_STEP;
                    div_phase_next = 1'b1;
                end
                else if (status.div_done)
                begin
                    cmd.op = mau_pkg::OP_GCD_STEP;
                    div_phase_next = 1'b0;
                end
            end
            mau_pkg::ST_INV_FIX:
            begin
                if (status.func == mau_pkg::FN_DIV && status.gcd_one && !status.m_is_one)
                begin
                    cmd.op = mau_pkg::OP_DIV_MUL;
                    cmd.sel_b = 1'b0;
                    state_next = mau_pkg::ST_DIV_MUL;
                end
                else
                    state_next = mau_pkg::ST_DONE;
            end
            mau_pkg::ST_DIV_MUL:
                if (status.div_done)
                begin
                    cmd.op = mau_pkg::OP_POW_SHIFT;
                    state_next = mau_pkg::ST_DONE;
                end
            mau_pkg::ST_DONE:
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = mau_pkg::ST_IDLE;
                end
            default:
                state_next = mau_pkg::ST_IDLE;
        endcase
    end

    `include "modular_arithmetic_unit_top_assert.svh"
    `MAU_ASSERT_IMPL(a_load_idle, clk, rst_n, in_fire, state_reg == mau_pkg::ST_IDLE)
    `MAU_ASSERT_NEXT(a_out_ret, clk, rst_n, out_load, state_reg == mau_pkg::ST_IDLE)
    `MAU_ASSERT_NEXT(a_fix_disp, clk, rst_n, state_reg == mau_pkg::ST_FIX, state_reg == mau_pkg::ST_DISPATCH)
endmodule
`default_nettype wire

### rtl/modular_arithmetic_unit_top.sv
// Top level of the modular arithmetic unit.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_stall  | mau_pkg::in_item_t
//  out     | out | out_valid / out_stall| mau_pkg::out_item_t
//  cfg     | in  | APB psel/penable     | modulus at address 0
//
// One item at a time. Each operand reduction and each multiply runs on a
// bit-serial divider. pow squares once per exponent bit and multiplies once
// per set bit; inverse and div take one divider pass per Euclid step, and div
// ends with a multiply when b is invertible and m is not 1.
// Reset sets the modulus to 1000000007 and empties the output register.
// A stalled result sits in the output register; the next item is taken then.
`default_nettype none
module modular_arithmetic_unit_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire mau_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output mau_pkg::out_item_t      out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [30:0] modulus_reg;
    logic        ovalid_reg;
    mau_pkg::out_item_t odata_reg, res;
    mau_pkg::dp_cmd_t cmd;
    mau_pkg::dp_status_t status;
    logic idle, out_load, in_fire, out_free;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mau_pkg::RegModulus) ? {1'b0, modulus_reg} : 32'd0;
    assign in_stall = !idle;
    assign in_fire = in_valid && idle;
    assign out_free = !ovalid_reg || !out_stall;
    assign out_valid = ovalid_reg;
    assign out_data = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= mau_pkg::ModulusReset;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2] == mau_pkg::RegModulus)
                modulus_reg <= pwdata[30:0];
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (!out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            odata_reg <= res;
    end

    mau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .status(status), .cmd(cmd), .idle(idle), .out_load(out_load)
    );

    mau_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .item(in_data), .m(modulus_reg),
        .status(status), .res(res)
    );

    `include "modular_arithmetic_unit_top_assert.svh"
    `MAU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `MAU_ASSERT_IMPL(a_no_fire_busy, clk, rst_n, in_stall, !in_fire)
    `MAU_ASSERT_IMPL(a_load_free, clk, rst_n, out_load, out_free)
endmodule
`default_nettype wire
